// File: rtl/dpalu_pkg.sv
// package: opcodes, shift types, operand and flag types shared by the alu modules
`timescale 1ns / 1ps

package dpalu_pkg;

   localparam int unsigned WORD_W = 32;

   // register index of the program counter and the read-ahead applied to it
   localparam logic [3:0]        REG_PC     = 4'hF;
   localparam logic [WORD_W-1:0] PC_AHEAD   = 32'd4;
   localparam logic [7:0]        PC_AHEAD_B = 8'd4;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } alu_op_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   // shifter output handed to the alu
   typedef struct packed {
      logic [WORD_W-1:0] op_a;
      logic [WORD_W-1:0] op_b;
      logic              shift_carry;
   } operands_type;

   function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] v,
                                               input logic [4:0] s);
      return (v >> s) | (v << (6'd32 - {1'b0, s}));
   endfunction

   function automatic logic is_compare(input alu_op_type op);
      return (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);
   endfunction

endpackage

// File: rtl/dpalu_shifter.sv
// barrel shifter: forms operand two, shifter carry and the pc-adjusted operand one
`timescale 1ns / 1ps

module dpalu_shifter
   import dpalu_pkg::*;
(
   input  logic        use_immediate,
   input  logic [11:0] operand_word,
   input  logic        first_is_pc,
   input  logic [31:0] first_value,
   input  logic [31:0] second_value,
   input  logic [7:0]  shift_reg_value,
   input  logic        carry_in,
   output operands_type operands
);

   logic [4:0]     rot_amt;
   logic [31:0]    imm_val;
   logic           by_reg;
   shift_kind_type kind;
   logic [7:0]     amt;
   logic [4:0]     amt_lo;
   logic           amt_zero;
   logic           amt_lt32;
   logic           amt_eq32;
   logic [31:0]    rm_val;
   logic [32:0]    lsl_wide;
   logic [32:0]    lsr_wide;
   logic [32:0]    asr_wide;
   logic [31:0]    ror_val;
   logic [31:0]    fill;
   logic [31:0]    op_b;
   logic           carry;

   assign rot_amt = {operand_word[11:8], 1'b0};
   assign imm_val = {24'd0, operand_word[7:0]};
   assign by_reg  = operand_word[4];
   assign kind    = shift_kind_type'(operand_word[6:5]);

   always_comb begin
      if (by_reg) begin
         amt = shift_reg_value + ((operand_word[11:8] == REG_PC) ? PC_AHEAD_B : 8'd0);
      end else if ((kind == SHIFT_LSR || kind == SHIFT_ASR) && operand_word[11:7] == 5'd0) begin
         // immediate lsr/asr #0 encode a shift by 32
         amt = 8'd32;
      end else begin
         amt = {3'd0, operand_word[11:7]};
      end
   end

   assign amt_lo   = amt[4:0];
   assign amt_zero = (amt == 8'd0);
   assign amt_lt32 = (amt < 8'd32);
   assign amt_eq32 = (amt == 8'd32);

   assign rm_val = (by_reg && operand_word[3:0] == REG_PC) ? second_value + PC_AHEAD
                                                           : second_value;

   // one extra bit catches the last bit shifted out
   assign lsl_wide = {1'b0, rm_val} << amt_lo;
   assign lsr_wide = {rm_val, 1'b0} >> amt_lo;
   assign asr_wide = 33'($signed({rm_val, 1'b0}) >>> amt_lo);
   assign ror_val  = ror32(rm_val, amt_lo);
   assign fill     = {32{rm_val[31]}};

   always_comb begin
      op_b  = rm_val;
      carry = carry_in;
      if (use_immediate) begin
         op_b = ror32(imm_val, rot_amt);
         if (rot_amt != 5'd0) begin
            carry = op_b[31];
         end
      end else if (!amt_zero) begin
         unique case (kind)
            SHIFT_LSL: begin
               op_b  = amt_lt32 ? lsl_wide[31:0] : 32'd0;
               carry = amt_lt32 ? lsl_wide[32] : (amt_eq32 ? rm_val[0] : 1'b0);
            end
            SHIFT_LSR: begin
               op_b  = amt_lt32 ? lsr_wide[32:1] : 32'd0;
               carry = amt_lt32 ? lsr_wide[0] : (amt_eq32 ? rm_val[31] : 1'b0);
            end
            SHIFT_ASR: begin
               op_b  = amt_lt32 ? asr_wide[32:1] : fill;
               carry = amt_lt32 ? asr_wide[0] : rm_val[31];
            end
            SHIFT_ROR: begin
               op_b  = ror_val;
               carry = ror_val[31];
            end
            default: begin
               op_b  = rm_val;
               carry = carry_in;
            end
         endcase
      end else if (kind == SHIFT_ROR && !by_reg) begin
         // immediate ror #0 is rrx
         op_b  = {carry_in, rm_val[31:1]};
         carry = rm_val[0];
      end
   end

   assign operands.op_a = (by_reg && !use_immediate && first_is_pc) ? first_value + PC_AHEAD
                                                                    : first_value;
   assign operands.op_b        = op_b;
   assign operands.shift_carry = carry;

endmodule

// File: rtl/dpalu_core.sv
// sixteen-operation alu with one shared adder and nzcv flag update
`timescale 1ns / 1ps

module dpalu_core
   import dpalu_pkg::*;
(
   input  alu_op_type   func,
   input  logic         set_flags,
   input  operands_type operands,
   input  flags_type    flags_in,
   output logic [31:0]  result,
   output logic         write_result,
   output flags_type    flags_out
);

   logic [31:0] add_a;
   logic [31:0] add_b;
   logic        add_cin;
   logic [32:0] sum;
   logic        arith;
   logic        compare;
   logic [31:0] a;
   logic [31:0] b;

   assign a = operands.op_a;
   assign b = operands.op_b;

   always_comb begin
      add_a   = a;
      add_b   = b;
      add_cin = 1'b0;
      unique case (func)
         OP_SUB, OP_CMP: begin add_b = ~b; add_cin = 1'b1; end
         OP_RSB: begin add_a = b; add_b = ~a; add_cin = 1'b1; end
         OP_ADC: add_cin = flags_in.c;
         OP_SBC: begin add_b = ~b; add_cin = flags_in.c; end
         OP_RSC: begin add_a = b; add_b = ~a; add_cin = flags_in.c; end
         default: begin add_a = a; add_b = b; add_cin = 1'b0; end
      endcase
   end

   assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

   always_comb begin
      arith = 1'b0;
      unique case (func)
         OP_AND, OP_TST: result = a & b;
         OP_EOR, OP_TEQ: result = a ^ b;
         OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC, OP_CMP, OP_CMN: begin
            result = sum[31:0];
            arith  = 1'b1;
         end
         OP_ORR: result = a | b;
         OP_MOV: result = b;
         OP_BIC: result = a & ~b;
         OP_MVN: result = ~b;
         default: result = ~b;
      endcase
   end

   assign compare      = is_compare(func);
   assign write_result = !compare;

   always_comb begin
      flags_out = flags_in;
      if (set_flags || compare) begin
         flags_out.n = result[31];
         flags_out.z = (result == 32'd0);
         if (arith) begin
            flags_out.c = sum[32];
            flags_out.v = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ result[31]);
         end else begin
            // logical ops keep v
            flags_out.c = operands.shift_carry;
         end
      end
   end

endmodule

// File: rtl/arm_data_processing_alu_top.sv
// top level: data-processing execute unit with input and result registers
`timescale 1ns / 1ps
//
// data-processing execute unit: barrel shifter followed by a 16-op alu
// - req_* channel: one instruction per transfer (opcode, s bit, operand field,
//   rn/rm/rs values and current nzcv flags), valid/ready handshake
// - rsp_* channel: one result per transfer (alu value, destination write
//   enable, new nzcv flags), valid/ready handshake
// - an accepted instruction lands in the input register; the shifter and the
//   alu (one 33-bit adder) sit between it and the result register
// - an accepted instruction is held in the input register, then in the result
//   register, and rsp_valid rises once it reaches the result register
// - throughput: one instruction per cycle while results are taken; each register holds one item and
//   hands it on in every cycle that the next stage can take it
// - the input register keeps taking transfers while a result waits, so a
//   stalled receiver costs nothing until both registers are full; then
//   req_ready drops and the held result stays on rsp_* unchanged
// - reset (synchronous, active high) empties both registers; the data registers are not reset
//
module arm_data_processing_alu_top
   import dpalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_func,
   input  logic        req_use_immediate,
   input  logic        req_set_flags,
   input  logic [11:0] req_operand_word,
   input  logic        req_first_is_pc,
   input  logic [31:0] req_first_value,
   input  logic [31:0] req_second_value,
   input  logic [7:0]  req_shift_reg_value,
   input  logic        req_flag_n_in,
   input  logic        req_flag_z_in,
   input  logic        req_flag_c_in,
   input  logic        req_flag_v_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result,
   output logic        rsp_write_result,
   output logic        rsp_flag_n_out,
   output logic        rsp_flag_z_out,
   output logic        rsp_flag_c_out,
   output logic        rsp_flag_v_out
);

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   alu_op_type  func_ff;
   logic        use_imm_ff;
   logic        set_flags_ff;
   logic [11:0] operand_word_ff;
   logic        first_is_pc_ff;
   logic [31:0] first_value_ff;
   logic [31:0] second_value_ff;
   logic [7:0]  shift_reg_value_ff;
   flags_type   flags_ff;

   // result register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] result_ff;
   logic [31:0] result_in;
   logic        write_result_ff;
   logic        write_result_in;
   flags_type   out_flags_ff;
   flags_type   out_flags_in;

   logic         out_free;
   logic         in_advance;
   logic         req_take;
   operands_type operands;

   // a stage may take a new item when it is empty or its content moves on this cycle
   assign out_free   = !out_valid_ff || rsp_ready;
   assign in_advance = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || out_free;
   assign req_take   = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = in_advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff            <= alu_op_type'(req_func);
         use_imm_ff         <= req_use_immediate;
         set_flags_ff       <= req_set_flags;
         operand_word_ff    <= req_operand_word;
         first_is_pc_ff     <= req_first_is_pc;
         first_value_ff     <= req_first_value;
         second_value_ff    <= req_second_value;
         shift_reg_value_ff <= req_shift_reg_value;
         flags_ff           <= '{n: req_flag_n_in, z: req_flag_z_in,
                                 c: req_flag_c_in, v: req_flag_v_in};
      end
   end

   dpalu_shifter u_shifter (
      .use_immediate   (use_imm_ff),
      .operand_word    (operand_word_ff),
      .first_is_pc     (first_is_pc_ff),
      .first_value     (first_value_ff),
      .second_value    (second_value_ff),
      .shift_reg_value (shift_reg_value_ff),
      .carry_in        (flags_ff.c),
      .operands        (operands)
   );

   dpalu_core u_core (
      .func         (func_ff),
      .set_flags    (set_flags_ff),
      .operands     (operands),
      .flags_in     (flags_ff),
      .result       (result_in),
      .write_result (write_result_in),
      .flags_out    (out_flags_in)
   );

   always_ff @(posedge clock) begin
      if (in_advance) begin
         result_ff       <= result_in;
         write_result_ff <= write_result_in;
         out_flags_ff    <= out_flags_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result       = result_ff;
   assign rsp_write_result = write_result_ff;
   assign rsp_flag_n_out   = out_flags_ff.n;
   assign rsp_flag_z_out   = out_flags_ff.z;
   assign rsp_flag_c_out   = out_flags_ff.c;
   assign rsp_flag_v_out   = out_flags_ff.v;

   // back-pressure only when both registers hold items and the receiver stalls
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("req_ready low while a register is free");

   // an item held in the input register behind a stalled result is not dropped
   a_hold_in_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("input item lost during stall");

   // without the s bit, non-compare ops pass the flags through unchanged
   a_flags_pass: assert property (@(posedge clock) disable iff (reset)
      (in_advance && !set_flags_ff && !is_compare(func_ff)) |=>
         (out_flags_ff == $past(flags_ff)))
      else $error("flags changed without s bit");

   // logical ops never touch the overflow flag
   a_logical_keeps_v: assert property (@(posedge clock) disable iff (reset)
      (in_advance && (func_ff == OP_AND || func_ff == OP_EOR || func_ff == OP_TST ||
                      func_ff == OP_TEQ || func_ff == OP_ORR || func_ff == OP_MOV ||
                      func_ff == OP_BIC || func_ff == OP_MVN)) |=>
         (out_flags_ff.v == $past(flags_ff.v)))
      else $error("logical op changed v");

   // compare ops never write the destination
   a_compare_no_write: assert property (@(posedge clock) disable iff (reset)
      (in_advance && is_compare(func_ff)) |=> !write_result_ff)
      else $error("compare op writes destination");

endmodule
